@@ src/assert_macros.svh @@
// Assertion macros for the RTL files (quaternion_arith_unit includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/qau_pkg.sv @@
package qau_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_CNJ = 3'd3;
  localparam logic [2:0] KIND_SCL = 3'd4;
  localparam logic [2:0] KIND_ROT = 3'd5;
  // Unassigned codes; they produce an all-zero result.
  localparam logic [2:0] KIND_RSV6 = 3'd6;
  localparam logic [2:0] KIND_RSV7 = 3'd7;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] a_s;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_s;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_s;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               saturated;
  } out_t;

  // Operand indexes of the Hamilton product: term m = comp*4 + j is
  // a[OPA_IDX[m]] * b[OPB_IDX[m]].
  localparam logic [1:0] OPA_IDX [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd2
  };
  localparam logic [1:0] OPB_IDX [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd2, 2'd1
  };

  // Exact sum of one component's four products with the product signs.
  function automatic logic signed [66:0] sum4(input logic signed [63:0] p0,
                                              input logic signed [63:0] p1,
                                              input logic signed [63:0] p2,
                                              input logic signed [63:0] p3,
                                              input logic [1:0] comp);
    logic signed [66:0] s;
    s = 67'(p0);
    if (comp == 2'd0) begin
      s = s - 67'(p1) - 67'(p2) - 67'(p3);
    end else begin
      s = s + 67'(p1) + 67'(p2) - 67'(p3);
    end
    return s;
  endfunction

  // Round Q32.32 half up to Q16.16 and saturate; bit 32 is the clip flag.
  function automatic logic [32:0] round_sat(input logic signed [66:0] v);
    logic signed [66:0] w;
    logic signed [50:0] q;
    w = v + 67'sd32768;
    q = w[66:16];
    if (q > 51'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (q < -51'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, q[31:0]};
  endfunction

endpackage

@@ src/quaternion_arith_unit.sv @@
// The done strobe is start carried through the valid registers v1 to v7.
// Throughput: one word per cycle; busy is always low, seven words in flight.
// The second product pass (rotation's t*conj(q)) sets the pipeline depth.
// Synchronous active-high reset clears the valid bits; words in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module quaternion_arith_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  qau_pkg::in_t  operand,
  output logic          done,
  output qau_pkg::out_t result
);
  import qau_pkg::*;

  logic               v1, v2, v3, v4, v5, v6, v7;
  logic [2:0]         k1, k2, k3, k4, k5, k6, k7;
  logic signed [31:0] a1 [4];
  logic signed [31:0] b1 [4];
  logic signed [31:0] f1;
  logic signed [31:0] a2 [4];
  logic signed [31:0] b2 [4];
  logic signed [63:0] p2 [16];
  logic signed [66:0] acc3 [4];
  logic signed [31:0] c3 [4];
  logic               satc3;
  logic signed [31:0] t4 [4];
  logic signed [31:0] c4 [4];
  logic               sat4;
  logic signed [63:0] p5 [16];
  logic signed [31:0] t5 [4];
  logic               sat5;
  logic signed [66:0] acc6 [4];
  logic signed [31:0] t6 [4];
  logic               sat6;
  logic signed [31:0] r7 [4];
  logic               sat7;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= start; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // Stage 1: input register; rotation uses a pure vector.
  always_ff @(posedge clk) begin
    k1 <= operand.kind;
    a1 <= '{operand.a_s, operand.a_x, operand.a_y, operand.a_z};
    b1 <= '{(operand.kind == KIND_ROT) ? 32'sd0 : operand.b_s,
            operand.b_x, operand.b_y, operand.b_z};
    f1 <= operand.factor;
  end

  // Stage 2: first product pass.
  always_ff @(posedge clk) begin
    k2 <= k1;
    a2 <= a1;
    b2 <= b1;
    for (int m = 0; m < 16; m++) begin
      if (k1 == KIND_SCL) begin
        p2[m] <= (m % 4 == 0) ? a1[m / 4] * f1 : 64'sd0;
      end else begin
        p2[m] <= a1[OPA_IDX[m]] * b1[OPB_IDX[m]];
      end
    end
  end

  // Stage 3: component sums and the conjugate of a; linear operations are lifted to
  // Q32.32 so the same rounding stage clips them.
  always_ff @(posedge clk) begin
    logic sc;
    sc = 1'b0;
    k3 <= k2;
    for (int k = 0; k < 4; k++) begin
      case (k2) inside
        KIND_ADD: acc3[k] <= (67'(a2[k]) + 67'(b2[k])) <<< 16;
        KIND_SUB: acc3[k] <= (67'(a2[k]) - 67'(b2[k])) <<< 16;
        KIND_CNJ: acc3[k] <= (k == 0) ? (67'(a2[k]) <<< 16) : ((-67'(a2[k])) <<< 16);
        KIND_MUL, KIND_SCL, KIND_ROT:
          acc3[k] <= sum4(p2[4*k], p2[4*k+1], p2[4*k+2], p2[4*k+3], 2'(k));
        default: acc3[k] <= '0;
      endcase
      if (k == 0) begin
        c3[k] <= a2[k];
      end else if (a2[k] == 32'sh8000_0000) begin
        c3[k] <= 32'sh7FFF_FFFF;
        sc = 1'b1;
      end else begin
        c3[k] <= -a2[k];
      end
    end
    satc3 <= sc && (k2 == KIND_ROT);
  end

  // Stage 4: round and saturate the first pass.
  always_ff @(posedge clk) begin
    logic [32:0] rs;
    logic        s;
    s = satc3;
    k4 <= k3;
    c4 <= c3;
    for (int k = 0; k < 4; k++) begin
      rs = round_sat(acc3[k]);
      t4[k] <= rs[31:0];
      s = s | rs[32];
    end
    sat4 <= s;
  end

  // Stage 5: second product pass, t * conj(q).
  always_ff @(posedge clk) begin
    k5 <= k4;
    t5 <= t4;
    sat5 <= sat4;
    for (int m = 0; m < 16; m++) begin
      p5[m] <= t4[OPA_IDX[m]] * c4[OPB_IDX[m]];
    end
  end

  // Stage 6: second pass sums.
  always_ff @(posedge clk) begin
    k6 <= k5;
    t6 <= t5;
    sat6 <= sat5;
    for (int k = 0; k < 4; k++) begin
      acc6[k] <= sum4(p5[4*k], p5[4*k+1], p5[4*k+2], p5[4*k+3], 2'(k));
    end
  end

  // Stage 7: output register.
  always_ff @(posedge clk) begin
    logic [32:0] rs;
    logic        s;
    s = sat6;
    k7 <= k6;
    for (int k = 0; k < 4; k++) begin
      rs = round_sat(acc6[k]);
      if (k6 == KIND_ROT) begin
        r7[k] <= (k == 0) ? 32'sd0 : rs[31:0];
        s = s | rs[32];
      end else begin
        r7[k] <= t6[k];
      end
    end
    sat7 <= s;
  end

  assign done             = v7;
  assign result.r_s       = r7[0];
  assign result.r_x       = r7[1];
  assign result.r_y       = r7[2];
  assign result.r_z       = r7[3];
  assign result.saturated = sat7;

  `ASSERT_IMPLIES(a_rot_scalar_zero, clk, rst, done && k7 == KIND_ROT, result.r_s == 32'sd0)
  `ASSERT_IMPLIES(a_unknown_zero, clk, rst, done && (k7 == KIND_RSV6 || k7 == KIND_RSV7), result == '0)
  `ASSERT_NEXT(a_pass_two_done, clk, rst, v6, done)
  `ASSERT_IMPLIES(a_done_traced, clk, rst, done, $past(v1, 6))

endmodule
